@@ design/cwfc_pkg.sv @@
package cwfc_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_MSB  = 8'h80;
   localparam logic [7:0] ERR_MAX  = 8'hFF;

   // result queue geometry
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   // configuration register map
   localparam int CSR_ADDR_W = 2;
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_DIRECTION = 2'd0
   } csr_addr_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       is_check;
      logic       crc_bad;
      logic [7:0] error_count;
      logic       last_out;
   } rsp_item_type;

   typedef struct packed {
      logic push;
      logic two;
   } push_ctl_type;

   // one byte of CRC-8, MSB first, eight shift steps
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

@@ design/cwfc_req_if.sv @@
interface cwfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_in;

   modport source (output valid, output byte_in, output last_in, input ready);
   modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

@@ design/cwfc_rsp_if.sv @@
interface cwfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       is_check;
   logic       crc_bad;
   logic [7:0] error_count;
   logic       last_out;

   modport source (output valid, output byte_out, output is_check, output crc_bad,
                   output error_count, output last_out, input ready);
   modport sink   (input valid, input byte_out, input is_check, input crc_bad,
                   input error_count, input last_out, output ready);
endinterface

@@ design/cwfc_rsp_queue.sv @@
module cwfc_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  cwfc_pkg::push_ctl_type       push_ctl,
   input  cwfc_pkg::rsp_item_type       item0,
   input  cwfc_pkg::rsp_item_type       item1,
   output logic [cwfc_pkg::Q_CNT_W-1:0] space,
   cwfc_rsp_if.source                   rsp
);

   cwfc_pkg::rsp_item_type entries_ff [cwfc_pkg::Q_DEPTH];

   logic [cwfc_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cwfc_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cwfc_pkg::Q_CNT_W-1:0] count_ff, count_in;
   logic [cwfc_pkg::Q_CNT_W-1:0] push_n;
   logic                         pop;
   cwfc_pkg::rsp_item_type       head;

   assign pop   = rsp.valid && rsp.ready;
   assign space = cwfc_pkg::Q_CNT_W'(cwfc_pkg::Q_DEPTH) - count_ff;

   always_comb begin
      if (!push_ctl.push) begin
         push_n = '0;
      end else if (push_ctl.two) begin
         push_n = cwfc_pkg::Q_CNT_W'(2);
      end else begin
         push_n = cwfc_pkg::Q_CNT_W'(1);
      end
      wr_ptr_in = wr_ptr_ff + cwfc_pkg::Q_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + cwfc_pkg::Q_PTR_W'(pop);
      count_in  = count_ff + push_n - cwfc_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ctl.push) begin
         entries_ff[wr_ptr_ff] <= item0;
         if (push_ctl.two) begin
            entries_ff[wr_ptr_ff + cwfc_pkg::Q_PTR_W'(1)] <= item1;
         end
      end
   end

   assign head            = entries_ff[rd_ptr_ff];
   assign rsp.valid       = (count_ff != '0);
   assign rsp.byte_out    = head.byte_out;
   assign rsp.is_check    = head.is_check;
   assign rsp.crc_bad     = head.crc_bad;
   assign rsp.error_count = head.error_count;
   assign rsp.last_out    = head.last_out;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cwfc_pkg::Q_CNT_W'(cwfc_pkg::Q_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_ctl.push |-> (push_n <= space + cwfc_pkg::Q_CNT_W'(pop)))
      else $error("result queue overflow");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue empty with unequal pointers");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && count_ff == cwfc_pkg::Q_CNT_W'(1) && !push_ctl.push) |=> !rsp.valid)
      else $error("result queue not empty after last pop");
`endif

endmodule

@@ design/crc8_word_framer_checker_top.sv @@
// CRC-8 word framer and checker. The byte stream is cut into 16-bit words of two
// bytes, each followed by a check byte (CRC-8, polynomial 0x31, seed 0xFF, MSB
// first, no final XOR), with the CRC restarting for every word. With direction
// at 0 (receive) every byte comes back out once; each third byte is flagged as a
// check byte, compared against the CRC of the two bytes before it, and a
// saturating per-transfer mismatch count rides along on every result. With
// direction at 1 (transmit) data bytes pass through and a generated check byte
// follows every second data byte as an extra result transaction. A byte with
// last_in set ends the transfer and clears position, CRC and count; a transfer
// ending mid-word leaves its trailing bytes unchecked. Each accepted byte is
// handled in the cycle it is taken and its results land in a four-entry result
// queue, so one byte is taken per clock as long as the queue has room for the
// results it will produce (one, or two in transmit at word end); in transmit the
// rate is bounded by the output side at three results per two bytes. Results are
// registered in the queue before they reach rsp. Change direction only while idle.
module crc8_word_framer_checker_top (
   input  logic                            clock,
   input  logic                            reset,
   cwfc_req_if.sink                        req,
   cwfc_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cwfc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic       direction_ff;
   logic [1:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] mis_ff, mis_in;

   logic       accept;
   logic       need_two;
   logic [cwfc_pkg::Q_CNT_W-1:0] need;
   logic [cwfc_pkg::Q_CNT_W-1:0] space;
   logic [7:0] crc_next;
   logic       bad;

   cwfc_pkg::push_ctl_type push_ctl;
   cwfc_pkg::rsp_item_type item0, item1;

   // configuration port: pready always high, single register
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == cwfc_pkg::REG_DIRECTION) begin
         csr_prdata = {31'b0, direction_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == cwfc_pkg::REG_DIRECTION) begin
         direction_ff <= csr_pwdata[0];
      end
   end

   // transmit at second byte of a word emits the data byte plus a check byte;
   // any nonzero position counts as second byte
   assign need_two = direction_ff && (pos_ff != 2'd0);
   assign need     = need_two ? cwfc_pkg::Q_CNT_W'(2) : cwfc_pkg::Q_CNT_W'(1);

   // hold off the source only when the queue cannot take this byte's results
   assign req.ready = (need <= space);
   assign accept    = req.valid && req.ready;

   assign crc_next = cwfc_pkg::crc8_byte(crc_ff, req.byte_in);
   assign bad      = (req.byte_in != crc_ff);

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      mis_in = mis_ff;
      item0  = '0;
      item1  = '0;
      item0.byte_out = req.byte_in;
      item0.last_out = req.last_in;

      if (direction_ff) begin
         item0.error_count = mis_ff;
         item1.byte_out    = crc_next;
         item1.is_check    = 1'b1;
         item1.error_count = mis_ff;
         item1.last_out    = req.last_in;
         if (need_two) begin
            item0.last_out = 1'b0;
            pos_in = 2'd0;
            crc_in = cwfc_pkg::CRC_INIT;
         end else begin
            pos_in = 2'd1;
            crc_in = crc_next;
         end
      end else if (!pos_ff[1]) begin
         // receive data byte: fold into the word CRC
         item0.error_count = mis_ff;
         pos_in = pos_ff + 2'd1;
         crc_in = crc_next;
      end else begin
         // receive check byte (position 2, or the unreachable 3)
         if (bad && mis_ff != cwfc_pkg::ERR_MAX) begin
            mis_in = mis_ff + 8'd1;
         end
         item0.is_check    = 1'b1;
         item0.crc_bad     = bad;
         item0.error_count = mis_in;
         pos_in = 2'd0;
         crc_in = cwfc_pkg::CRC_INIT;
      end

      // end of transfer: drop all word and count state
      if (req.last_in) begin
         pos_in = 2'd0;
         crc_in = cwfc_pkg::CRC_INIT;
         mis_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         crc_ff <= cwfc_pkg::CRC_INIT;
         mis_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         mis_ff <= mis_in;
      end
   end

   assign push_ctl.push = accept;
   assign push_ctl.two  = need_two;

   cwfc_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_ctl (push_ctl),
      .item0    (item0),
      .item1    (item1),
      .space    (space),
      .rsp      (rsp)
   );

endmodule
